// ===== hdl/timed_message_queue_defines.svh =====
// ----------------------------------------------------------------------------
// timed message queue assertion macros
// concurrent assertion helpers clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef TIMED_MESSAGE_QUEUE_DEFINES_SVH
`define TIMED_MESSAGE_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TMQ_ASSERT_NEVER(label, expr, msg) \
  `TMQ_ASSERT(label, !(expr), msg)
`else
`define TMQ_ASSERT(label, prop, msg)
`define TMQ_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== hdl/tmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_pkg
// item, result, entry and configuration types of the timed message queue
// ----------------------------------------------------------------------------
package tmq_pkg;

  localparam int OCC_W     = 5;
  localparam int LIMIT_W   = 5;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 8'd1;

  typedef enum logic [1:0] {
    OP_POST   = 2'd0,
    OP_POLL   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_STOPPED   = 3'd2,
    ST_NOT_DUE   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] msg_id;
    logic [15:0] payload_ref;
    logic [31:0] delay_us;
    logic [63:0] now_us;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      out_id;
    logic [15:0]      out_ref;
    logic             found;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  typedef struct packed {
    logic [63:0] due_time;
    logic [15:0] entry_id;
    logic [15:0] entry_ref;
  } entry_t;

  typedef struct packed {
    logic               run_enable;
    logic [LIMIT_W-1:0] queue_limit;
  } cfg_t;

endpackage

// ===== hdl/tmq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmq_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tmq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/tmq_engine.sv =====
`timescale 1ns / 1ps
`include "timed_message_queue_defines.svh"
// ----------------------------------------------------------------------------
// tmq_engine
// sequencer that walks the entry ram to insert, pop, remove and look up items
// ----------------------------------------------------------------------------
module tmq_engine #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tmq_pkg::cfg_t            cfg,
  input  logic                     start,
  output logic                     busy,
  input  tmq_pkg::cmd_t            cmd,
  output logic                     done,
  output tmq_pkg::result_t         result,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  tmq_pkg::entry_t          rd_data,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output tmq_pkg::entry_t          wr_data
);

  import tmq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POST,
    S_INS,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [IW-1:0] ptr;
  op_t           op_q;
  logic [15:0]   id_q;
  logic [15:0]   ref_q;
  logic [63:0]   when_q;
  logic [63:0]   now_q;

  logic [CW-1:0] cnt_m1;
  logic          last;
  logic          full;
  logic          later;
  logic          hit;
  logic          quick;
  entry_t        new_entry;

  assign cnt_m1    = count - CW'(1);
  assign last      = (CW'(ptr) == cnt_m1);
  assign full      = (LW'(count) >= LW'(cfg.queue_limit)) || (count == CW'(DEPTH));
  assign later     = (rd_data.due_time > when_q);
  assign hit       = (op_q == OP_POLL) ? (rd_data.due_time <= now_q) : (rd_data.entry_id == id_q);
  assign new_entry = '{due_time: when_q, entry_id: id_q, entry_ref: ref_q};
  assign busy      = (state != S_IDLE);

  // item answered without walking the ram
  always_comb begin
    unique case (cmd.op)
      OP_POST: quick = !cfg.run_enable || full;
      OP_POLL: quick = !cfg.run_enable || (count == '0);
      default: quick = (count == '0);
    endcase
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_entry;
    unique case (state)
      S_IDLE: begin
        rd_addr = (cmd.op == OP_POST) ? IW'(cnt_m1) : '0;
      end
      S_POST: begin
        rd_addr = ptr - IW'(1);
        wr_en   = 1'b1;
        wr_addr = ptr + IW'(1);
        wr_data = later ? rd_data : new_entry;
      end
      S_INS: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        rd_addr = ptr + IW'(1);
      end
      S_SHIFT: begin
        rd_addr = ptr + IW'(1);
        wr_en   = 1'b1;
        wr_addr = ptr - IW'(1);
        wr_data = rd_data;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= start && quick;
          if (start) begin
            op_q             <= cmd.op;
            id_q             <= cmd.msg_id;
            ref_q            <= cmd.payload_ref;
            when_q           <= cmd.now_us + 64'(cmd.delay_us);
            now_q            <= cmd.now_us;
            ptr              <= (cmd.op == OP_POST) ? IW'(cnt_m1) : '0;
            result.out_id    <= '0;
            result.out_ref   <= '0;
            result.found     <= 1'b0;
            result.occupancy <= OCC_W'(count);
            unique case (cmd.op)
              OP_POST: begin
                if (!cfg.run_enable) begin
                  result.status <= ST_STOPPED;
                end else if (full) begin
                  result.status <= ST_FULL;
                end else begin
                  result.status <= ST_OK;
                  state         <= (count == '0) ? S_INS : S_POST;
                end
              end
              OP_POLL: begin
                if (!cfg.run_enable) begin
                  result.status <= ST_STOPPED;
                end else if (count == '0) begin
                  result.status <= ST_NOT_DUE;
                end else begin
                  result.status <= ST_OK;
                  state         <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                if (count == '0) begin
                  result.status <= ST_NOT_FOUND;
                end else begin
                  result.status <= ST_OK;
                  state         <= S_SCAN;
                end
              end
              OP_QUERY: begin
                result.status <= ST_OK;
                if (count != '0) begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_POST: begin
          done <= !later;
          if (later) begin
            if (ptr == '0) begin
              state <= S_INS;
            end else begin
              ptr <= ptr - IW'(1);
            end
          end else begin
            count            <= count + CW'(1);
            result.occupancy <= OCC_W'(count + CW'(1));
            state            <= S_IDLE;
          end
        end
        S_INS: begin
          done             <= 1'b1;
          count            <= count + CW'(1);
          result.occupancy <= OCC_W'(count + CW'(1));
          state            <= S_IDLE;
        end
        S_SCAN: begin
          done <= last || (hit ? (op_q == OP_QUERY) : (op_q == OP_POLL));
          if (hit) begin
            if (op_q == OP_QUERY) begin
              result.found <= 1'b1;
              state        <= S_IDLE;
            end else begin
              result.out_id  <= rd_data.entry_id;
              result.out_ref <= rd_data.entry_ref;
              if (last) begin
                count            <= cnt_m1;
                result.occupancy <= OCC_W'(cnt_m1);
                state            <= S_IDLE;
              end else begin
                ptr   <= ptr + IW'(1);
                state <= S_SHIFT;
              end
            end
          end else if (op_q == OP_POLL) begin
            result.status <= ST_NOT_DUE;
            state         <= S_IDLE;
          end else if (last) begin
            if (op_q == OP_REMOVE) begin
              result.status <= ST_NOT_FOUND;
            end
            state <= S_IDLE;
          end else begin
            ptr <= ptr + IW'(1);
          end
        end
        S_SHIFT: begin
          done <= last;
          if (last) begin
            count            <= cnt_m1;
            result.occupancy <= OCC_W'(cnt_m1);
            state            <= S_IDLE;
          end else begin
            ptr <= ptr + IW'(1);
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TMQ_ASSERT_NEVER(a_count_max, count > CW'(DEPTH), "fill count beyond depth")
  `TMQ_ASSERT(a_ptr_range, (busy && state != S_INS) |-> (CW'(ptr) < count), "pointer past count")
  `TMQ_ASSERT(a_count_hold, (!done && !$past(rst)) |-> (count == $past(count)), "count moved")
  `TMQ_ASSERT(a_post_grows, (done && op_q == OP_POST && result.status == ST_OK) |-> (count == $past(count) + CW'(1)), "post not added")
  `TMQ_ASSERT(a_occ_match, done |-> (result.occupancy == OCC_W'(count)), "occupancy differs from fill count")

endmodule

// ===== hdl/timed_message_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_message_queue
// bounded queue of messages held in due-time order in a single entry ram
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive cmd and raise start; an item is taken at a clock
//   edge with start high and busy low. busy stays high while the item runs.
//   result channel: done is high for one cycle with result valid; there is no
//   back pressure, so the receiver must take it in that cycle.
//   config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are both high; cfg_ready is always high. index 0 run_enable, 1 queue_limit.
//   sequencing: immediate answers (stopped, full, or an empty queue on a poll,
//   remove or query) raise done in the cycle after the accept edge; otherwise
//   the engine walks the entry ram through its single read and write port: a
//   post moves later entries back one place and a poll, remove or query scans
//   from the head, a poll or remove hit shifting the later entries forward.
//   a new item may be taken in the cycle that done is high.
//   reset: empty queue, run_enable 0, queue_limit 16; ram contents are not
//   cleared and only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module timed_message_queue #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tmq_pkg::cmd_t                  cmd,
  output logic                           done,
  output tmq_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmq_pkg::CFG_DAT_W-1:0]  cfg_data
);

  import tmq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  cfg_t          cfg;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          wr_en;
  entry_t        rd_data;
  entry_t        wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_enable  <= 1'b0;
      cfg.queue_limit <= QUEUE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RUN_ENABLE:  cfg.run_enable  <= cfg_data[0];
        REG_QUEUE_LIMIT: cfg.queue_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tmq_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tmq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== tb/timed_message_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_message_queue_test
// drives post, poll, remove and query items through the command port and
// checks every result against a shadow copy of the due-time ordered queue
// or a hand-written answer; a short table of hand-picked items comes first,
// then random phases, each under its own run_enable and queue_limit setting
// ----------------------------------------------------------------------------
module timed_message_queue_test;

  import tmq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 96;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    cmd_t                 item;
    bit                   typed;
    result_t              answer;
  } plan_step_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  cmd_t                 cmd = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  entry_t       waiting[DEPTH];
  int           waiting_count;
  logic         shadow_run;
  logic [4:0]   shadow_limit;
  result_t      pending_results[$];
  plan_step_t   plan[$];
  int           mismatches = 0;
  int           cycle_count = 0;

  timed_message_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed_message_queue_test: errors");
      $finish;
    end
  end

  // shadow queue: removes the entry at pos and closes the gap
  function automatic void drop_waiting(int pos);
    int k;
    for (k = pos; k + 1 < waiting_count; k++) waiting[k] = waiting[k + 1];
    waiting_count--;
  endfunction

  function automatic int find_waiting(logic [15:0] id);
    int k;
    for (k = 0; k < waiting_count; k++) begin
      if (waiting[k].entry_id == id) return k;
    end
    return waiting_count;
  endfunction

  function automatic result_t predict_queue_op(cmd_t c);
    result_t     r;
    int          pos;
    int          k;
    int          eff_limit;
    logic [63:0] when;
    r = '0;
    r.status = ST_OK;
    eff_limit = (shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit);
    case (c.op)
      OP_POST: begin
        if (!shadow_run) begin
          r.status = ST_STOPPED;
        end else if (waiting_count >= eff_limit) begin
          r.status = ST_FULL;
        end else begin
          when = c.now_us + 64'(c.delay_us);
          pos = 0;
          while (pos < waiting_count && waiting[pos].due_time <= when) pos++;
          for (k = waiting_count; k > pos; k--) waiting[k] = waiting[k - 1];
          waiting[pos] = '{due_time: when, entry_id: c.msg_id, entry_ref: c.payload_ref};
          waiting_count++;
        end
      end
      OP_POLL: begin
        if (!shadow_run) begin
          r.status = ST_STOPPED;
        end else if (waiting_count == 0 || waiting[0].due_time > c.now_us) begin
          r.status = ST_NOT_DUE;
        end else begin
          r.out_id = waiting[0].entry_id;
          r.out_ref = waiting[0].entry_ref;
          drop_waiting(0);
        end
      end
      OP_REMOVE: begin
        pos = find_waiting(c.msg_id);
        if (pos >= waiting_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.out_id = waiting[pos].entry_id;
          r.out_ref = waiting[pos].entry_ref;
          drop_waiting(pos);
        end
      end
      default: begin
        r.found = (find_waiting(c.msg_id) < waiting_count);
      end
    endcase
    r.occupancy = waiting_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic plan_step_t item_row(op_t op, logic [15:0] id, logic [15:0] pref,
                                          logic [31:0] delay, logic [63:0] now);
    plan_step_t s;
    s = '{default: '0};
    s.item = '{op: op, msg_id: id, payload_ref: pref, delay_us: delay, now_us: now};
    return s;
  endfunction

  function automatic plan_step_t checked_row(op_t op, logic [15:0] id, logic [15:0] pref,
                                             logic [31:0] delay, logic [63:0] now,
                                             status_t st, logic [15:0] oid,
                                             logic [15:0] oref, logic fnd, int occ);
    plan_step_t s;
    s = item_row(op, id, pref, delay, now);
    s.typed = 1'b1;
    s.answer = '{status: st, out_id: oid, out_ref: oref, found: fnd,
                 occupancy: occ[OCC_W-1:0]};
    return s;
  endfunction

  function automatic plan_step_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DAT_W-1:0] val);
    plan_step_t s;
    s = '{default: '0};
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic void add_step(plan_step_t s);
    plan.insert(plan.size(), s);
  endfunction

  task automatic send_item(cmd_t c, bit typed, result_t answer);
    result_t predicted;
    @(negedge clk);
    cmd = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predicted = predict_queue_op(c);
    pending_results.insert(pending_results.size(), typed ? answer : predicted);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RUN_ENABLE) shadow_run = val[0];
    else if (idx == REG_QUEUE_LIMIT) shadow_limit = val[4:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(logic run_en, logic [CFG_DAT_W-1:0] limit_val,
                           logic [63:0] tbase, bit idle_on);
    cmd_t        c;
    logic [15:0] id_base;
    logic [63:0] clock_off;
    int          sel;
    int          n;
    write_register(REG_RUN_ENABLE, {15'($urandom_range(0, 32767)), run_en});
    write_register(REG_QUEUE_LIMIT, limit_val);
    id_base = $urandom;
    clock_off = '0;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) c.op = OP_POST;
      else if (sel < 75) c.op = OP_POLL;
      else if (sel < 88) c.op = OP_REMOVE;
      else c.op = OP_QUERY;
      c.msg_id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                              : id_base + 16'($urandom_range(0, 5));
      if (c.op inside {OP_REMOVE, OP_QUERY} && waiting_count > 0 && $urandom_range(0, 1))
        c.msg_id = waiting[$urandom_range(0, waiting_count - 1)].entry_id;
      c.payload_ref = $urandom;
      c.delay_us = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 300));
      clock_off += 64'($urandom_range(0, 60));
      c.now_us = ($urandom_range(0, 19) == 0) ? {32'($urandom), 32'($urandom)}
                                               : tbase + clock_off;
      send_item(c, 1'b0, '0);
      if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          mismatches++;
        end
        if (result.out_id !== want.out_id) begin
          $error("out_id: expected %0h, actual %0h", want.out_id, result.out_id);
          mismatches++;
        end
        if (result.out_ref !== want.out_ref) begin
          $error("out_ref: expected %0h, actual %0h", want.out_ref, result.out_ref);
          mismatches++;
        end
        if (result.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, result.found);
          mismatches++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, result.occupancy);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [63:0]          tbase;
    logic [CFG_DAT_W-1:0] limit_val;
    logic                 run_en;
    int                   p;
    waiting_count = 0;
    shadow_run = 1'b0;
    shadow_limit = QUEUE_LIMIT_RESET;

    // stopped after reset
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, 64'h0,
                         ST_STOPPED, 16'h0, 16'h0, 1'b0, 0));
    add_step(checked_row(OP_POST, 16'hffff, 16'hffff, 32'hffff_ffff, '1,
                         ST_STOPPED, 16'h0, 16'h0, 1'b0, 0));
    add_step(checked_row(OP_QUERY, 16'h0, 16'h0, 32'h0, 64'h0,
                         ST_OK, 16'h0, 16'h0, 1'b0, 0));
    add_step(checked_row(OP_REMOVE, 16'hffff, 16'h0, 32'h0, 64'h0,
                         ST_NOT_FOUND, 16'h0, 16'h0, 1'b0, 0));
    add_step(cfg_row(REG_RUN_ENABLE, 16'h1));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, '1,
                         ST_NOT_DUE, 16'h0, 16'h0, 1'b0, 0));
    // due time wraps past the top of the 64-bit range
    add_step(checked_row(OP_POST, 16'hffff, 16'hffff, 32'hffff_ffff, '1,
                         ST_OK, 16'h0, 16'h0, 1'b0, 1));
    add_step(checked_row(OP_POST, 16'h0, 16'h0, 32'h0, 64'h0,
                         ST_OK, 16'h0, 16'h0, 1'b0, 2));
    // equal due time goes behind the earlier post
    add_step(item_row(OP_POST, 16'h1, 16'h1, 32'h0, 64'h0));
    add_step(item_row(OP_POST, 16'h1, 16'h2, 32'hffff_ffff, 64'hffff_ffff_0000_0000));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, 64'h0,
                         ST_OK, 16'h0, 16'h0, 1'b0, 3));
    add_step(item_row(OP_POLL, 16'h0, 16'h0, 32'h0, 64'h0));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, 64'h0,
                         ST_NOT_DUE, 16'h0, 16'h0, 1'b0, 2));
    add_step(checked_row(OP_QUERY, 16'hffff, 16'h0, 32'h0, 64'h0,
                         ST_OK, 16'h0, 16'h0, 1'b1, 2));
    // limit below occupancy
    add_step(cfg_row(REG_QUEUE_LIMIT, 16'h1));
    add_step(checked_row(OP_POST, 16'h5, 16'h5, 32'h0, 64'h0,
                         ST_FULL, 16'h0, 16'h0, 1'b0, 2));
    // stopped: poll refused, remove and query still work
    add_step(cfg_row(REG_RUN_ENABLE, 16'h0));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, '1,
                         ST_STOPPED, 16'h0, 16'h0, 1'b0, 2));
    add_step(checked_row(OP_REMOVE, 16'h1, 16'h0, 32'h0, 64'h0,
                         ST_OK, 16'h1, 16'h2, 1'b0, 1));
    add_step(checked_row(OP_QUERY, 16'h1, 16'h0, 32'h0, 64'h0,
                         ST_OK, 16'h0, 16'h0, 1'b0, 1));
    // zero limit refuses every post
    add_step(cfg_row(REG_RUN_ENABLE, 16'h1));
    add_step(cfg_row(REG_QUEUE_LIMIT, 16'h0));
    add_step(checked_row(OP_POST, 16'h6, 16'h6, 32'h0, 64'h0,
                         ST_FULL, 16'h0, 16'h0, 1'b0, 1));
    // unknown register indexes are ignored, limit above depth acts as depth
    add_step(cfg_row(8'd2, 16'h0));
    add_step(cfg_row(8'hff, 16'hffff));
    add_step(cfg_row(REG_QUEUE_LIMIT, 16'd31));
    add_step(checked_row(OP_POST, 16'h7, 16'h7, 32'd10, 64'hffff_ffff_ffff_fff8,
                         ST_OK, 16'h0, 16'h0, 1'b0, 2));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, 64'd1,
                         ST_NOT_DUE, 16'h0, 16'h0, 1'b0, 2));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, 64'd2,
                         ST_OK, 16'h7, 16'h7, 1'b0, 1));
    add_step(checked_row(OP_POLL, 16'h0, 16'h0, 32'h0, '1,
                         ST_OK, 16'hffff, 16'hffff, 1'b0, 0));
    add_step(checked_row(OP_REMOVE, 16'h7, 16'h0, 32'h0, 64'h0,
                         ST_NOT_FOUND, 16'h0, 16'h0, 1'b0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) write_register(plan[i].reg_idx, plan[i].reg_val);
      else send_item(plan[i].item, plan[i].typed, plan[i].answer);
    end

    for (p = 0; p < PHASES; p++) begin
      tbase = {32'($urandom), 32'($urandom)};
      run_en = 1'b1;
      case (p)
        0: limit_val = 16'd16;
        1: limit_val = 16'd1;
        2: begin
          limit_val = 16'd31;
          tbase = 64'hffff_ffff_ffff_fe00;
        end
        3: begin
          limit_val = 16'd16;
          run_en = 1'b0;
        end
        4: limit_val = 16'd0;
        5: limit_val = 16'd17;
        default: begin
          limit_val = {11'($urandom), 5'($urandom_range(0, 20))};
          run_en = ($urandom_range(0, 5) != 0);
        end
      endcase
      run_phase(run_en, limit_val, tbase, p != PHASES - 1);
    end

    wait_drained();
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("timed_message_queue_test: clean");
    end else begin
      $display("timed_message_queue_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tmq_pkg.sv
hdl/tmq_ram.sv
hdl/tmq_engine.sv
hdl/timed_message_queue.sv
tb/timed_message_queue_test.sv
